// File: rtl/core/iou_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package iou_pkg;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 104;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [23:0] LOSS_MAX  = 24'hFFFFFF;

  typedef struct packed {
    logic signed [17:0] lt;
    logic signed [17:0] pr;
    logic signed [17:0] mi;
    logic               gt;
  } lane_out_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] val;
    logic [63:0] res;
    logic [63:0] bt;
    val = v;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bt > val) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (val >= res + bt) begin
          val = val - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // 2^30 * 2^(-2^-k)
  function automatic logic [29:0] pow_tab_f(input int k);
    logic [63:0] e;
    e = 64'd1 << 29;
    for (int j = 1; j <= 20; j++) begin
      if (j <= k) e = isqrt64(e << 30);
    end
    return e[29:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/iou_lg2.sv
`timescale 1ns / 1ps
`default_nettype none
module iou_lg2 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [33:0] v_i,
  output logic      [25:0] lg_o
);
  import iou_pkg::*;

  logic [33:0] vv;
  logic [5:0]  p_nxt;
  logic [30:0] m_nxt;
  logic [63:0] shl;

  logic [30:0] m_r [0:20];
  logic [19:0] f_r [0:20];
  logic [5:0]  p_r [0:20];

  always_comb begin
    vv    = (v_i == 34'd0) ? 34'd1 : v_i;
    p_nxt = '0;
    for (int i = 0; i < 34; i++) begin
      if (vv[i]) p_nxt = 6'(i);
    end
    shl = 64'(vv) << (6'd30 - p_nxt);
    if (p_nxt <= 6'd30) m_nxt = shl[30:0];
    else                m_nxt = 31'(vv >> (p_nxt - 6'd30));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= m_nxt;
      f_r[0] <= '0;
      p_r[0] <= p_nxt;
    end
  end

  for (genvar k = 1; k <= 20; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = 62'(m_r[k-1]) * 62'(m_r[k-1]);
    assign t  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k] <= t[31] ? t[31:1] : t[30:0];
        f_r[k] <= {f_r[k-1][18:0], t[31]};
        p_r[k] <= p_r[k-1];
      end
    end
  end

  assign lg_o = {p_r[20], f_r[20]};

endmodule
`default_nettype wire

// File: rtl/core/iou_exp.sv
`timescale 1ns / 1ps
`default_nettype none
module iou_exp (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [19:0] z_i,
  output logic      [30:0] e_o
);
  import iou_pkg::*;

  logic [50:0] wp;
  logic [29:0] w_nxt;
  logic [30:0] r_r [0:20];
  logic [19:0] f_r [0:20];
  logic [9:0]  n_r [0:20];
  logic [30:0] e_r;

  assign wp    = 51'(z_i) * 51'(LOG2E_Q30) + 51'd2097152;
  assign w_nxt = 30'(wp[51-1:22]);

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= 31'h4000_0000;
      f_r[0] <= w_nxt[19:0];
      n_r[0] <= w_nxt[29:20];
    end
  end

  for (genvar k = 1; k <= 20; k++) begin : g_mul
    localparam logic [29:0] TAB = pow_tab_f(k);
    logic [60:0] prod;
    assign prod = 61'(r_r[k-1]) * 61'(TAB);
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= f_r[k-1][20-k] ? prod[60:30] : r_r[k-1];
        f_r[k] <= f_r[k-1];
        n_r[k] <= n_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) e_r <= (n_r[20] >= 10'd31) ? 31'd0 : (r_r[20] >> n_r[20]);
  end

  assign e_o = e_r;

endmodule
`default_nettype wire

// File: rtl/core/iou_div.sv
`timescale 1ns / 1ps
`default_nettype none
module iou_div (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic        [32:0] num_i,
  input  wire logic               neg_i,
  input  wire logic        [33:0] den_i,
  output logic signed      [18:0] q_o
);
  import iou_pkg::*;

  logic [50:0] nn;
  logic [34:0] rem_r [0:18];
  logic [17:0] nb_r  [0:18];
  logic [33:0] dd_r  [0:18];
  logic [17:0] q_r   [0:18];
  logic        sg_r  [0:18];

  // rounded numerator, quotient known to fit 18 bits
  assign nn = (51'(num_i) << 16) + 51'(den_i >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 35'(nn[50:18]);
      nb_r[0]  <= nn[17:0];
      dd_r[0]  <= den_i;
      q_r[0]   <= '0;
      sg_r[0]  <= neg_i;
    end
  end

  for (genvar k = 1; k <= 18; k++) begin : g_step
    logic [35:0] cand;
    logic        ge;
    assign cand = {rem_r[k-1], nb_r[k-1][17]};
    assign ge   = cand >= 36'(dd_r[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? 35'(cand - 36'(dd_r[k-1])) : cand[34:0];
        nb_r[k]  <= {nb_r[k-1][16:0], 1'b0};
        dd_r[k]  <= dd_r[k-1];
        q_r[k]   <= {q_r[k-1][16:0], ge};
        sg_r[k]  <= sg_r[k-1];
      end
    end
  end

  assign q_o = sg_r[18] ? -$signed({1'b0, q_r[18]}) : $signed({1'b0, q_r[18]});

endmodule
`default_nettype wire

// File: rtl/core/iou_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module iou_lane (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [16:0] tgt_i,
  input  wire logic signed [17:0] prd_i,
  output iou_pkg::lane_out_t      lo_o
);
  import iou_pkg::*;

  logic [25:0]        lg;
  logic signed [17:0] pd_r [0:20];
  logic signed [26:0] l2;
  logic signed [57:0] prod;
  logic signed [57:0] sum;
  logic signed [17:0] lt;
  lane_out_t          lo_r;

  iou_lg2 u_lg2 (
    .clk  (clk),
    .en   (en),
    .v_i  ({18'd0, tgt_i[15:0]}),
    .lg_o (lg)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= prd_i;
      for (int i = 1; i <= 20; i++) pd_r[i] <= pd_r[i-1];
    end
  end

  // ln(t/16) in Q.12
  assign l2   = $signed({1'b0, lg}) - 27'sd4194304;
  assign prod = l2 * $signed({1'b0, LN2_Q30});
  assign sum  = prod + 58'sd137438953472;
  assign lt   = $signed(sum[55:38]);

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r.lt <= lt;
      lo_r.pr <= pd_r[20];
      lo_r.mi <= (lt < pd_r[20]) ? lt : pd_r[20];
      lo_r.gt <= lt > pd_r[20];
    end
  end

  assign lo_o = lo_r;

endmodule
`default_nettype wire

// File: rtl/core/iou_loss_with_gradient_top.sv
`timescale 1ns / 1ps
`default_nettype none
// IoU loss with gradient, one box location per transfer.
// Input channel in_*: one transfer carries four target distances and four
// predicted log distances. Output channel out_*: one transfer per input
// with loss, the four negated side gradients and the valid flag in tuser.
// Four side lanes take target logs, twelve exp units evaluate the corner
// terms, eight pipelined dividers form the gradient ratios and two log2
// units form the loss.
// Throughput: one item per cycle unless out_tready stalls the pipeline; the
// squaring, multiply and divide steps are each one pipeline stage.
// When out_tready is low with out_tvalid high, the whole pipeline holds and
// in_tready drops in the same cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and clears out_tvalid.
// An item with any non-positive target gives valid 0 and all-zero data.
module iou_loss_with_gradient_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // target_left, target_top, target_right, target_bottom,
  // pred_left, pred_top, pred_right, pred_bottom, 4 zero bits
  input  wire logic [iou_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // loss, grad_left, grad_top, grad_right, grad_bottom
  output logic [iou_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // valid_res
  output logic                                out_tuser
);
  import iou_pkg::*;

  localparam int VERT [4] = '{1, 1, 3, 3};
  localparam int HORZ [4] = '{0, 2, 0, 2};
  localparam int SC0  [4] = '{0, 0, 1, 2};
  localparam int SC1  [4] = '{2, 1, 3, 3};

  logic en;
  logic ok_in;

  logic [72:1] vld_r;
  logic [72:1] ok_r;

  logic signed [16:0] tgt [4];
  logic signed [17:0] prd [4];
  lane_out_t          lo  [4];

  logic signed [18:0] tm1_r [12];
  logic signed [18:0] tm2_r [12];
  logic signed [18:0] tm3_r [12];
  logic signed [18:0] gmax_nxt [3];
  logic signed [18:0] gmax_r [3];
  logic signed [18:0] mx_r;
  logic [19:0]        z [12];
  logic [30:0]        ex [12];

  logic [3:0]  gt_r [1:26];
  logic [3:0]  gts;

  logic [32:0] x_r, xh_r, i_r;
  logic [31:0] eps_r [4];
  logic [31:0] eis_r [4];

  logic [33:0] s_sum, u_nxt;
  logic [33:0] u_r;
  logic [32:0] i2_r;
  logic        iz_r;
  logic [32:0] n1_r [4];
  logic [33:0] d1_r [4];
  logic [32:0] n2_r [4];
  logic        ng_r [4];

  logic [25:0] lgu, lgi;
  logic [21:1] izd_r;
  logic signed [26:0] ldiff;
  logic [25:0] diff_r;
  logic        lz_r;
  logic [55:0] lp;
  logic [23:0] loss_r;

  logic signed [18:0] q1 [4];
  logic signed [18:0] q2 [4];
  logic signed [19:0] g_r  [4];
  logic signed [19:0] gd_r [1:3][4];

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  assign en        = ~out_tvalid_r | out_tready;
  assign in_tready = en;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    assign tgt[i] = $signed(in_tdata[17*i +: 17]);
    assign prd[i] = $signed(in_tdata[68 + 18*i +: 18]);
    iou_lane u_lane (
      .clk   (clk),
      .en    (en),
      .tgt_i (tgt[i]),
      .prd_i (prd[i]),
      .lo_o  (lo[i])
    );
    assign gts[i] = lo[i].gt;
  end

  assign ok_in = (tgt[0] > 17'sd0) && (tgt[1] > 17'sd0) &&
                 (tgt[2] > 17'sd0) && (tgt[3] > 17'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[71:1], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) ok_r <= {ok_r[71:1], ok_in};
  end

  // corner terms: target, prediction, intersection
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        tm1_r[c]     <= 19'(lo[VERT[c]].lt) + 19'(lo[HORZ[c]].lt);
        tm1_r[4 + c] <= 19'(lo[VERT[c]].pr) + 19'(lo[HORZ[c]].pr);
        tm1_r[8 + c] <= 19'(lo[VERT[c]].mi) + 19'(lo[HORZ[c]].mi);
      end
    end
  end

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      gmax_nxt[g] = tm1_r[4*g];
      for (int j = 1; j < 4; j++) begin
        if (tm1_r[4*g + j] > gmax_nxt[g]) gmax_nxt[g] = tm1_r[4*g + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gmax_r <= gmax_nxt;
      tm2_r  <= tm1_r;
      tm3_r  <= tm2_r;
      if (gmax_r[0] >= gmax_r[1] && gmax_r[0] >= gmax_r[2]) mx_r <= gmax_r[0];
      else if (gmax_r[1] >= gmax_r[2])                       mx_r <= gmax_r[1];
      else                                                   mx_r <= gmax_r[2];
    end
  end

  for (genvar j = 0; j < 12; j++) begin : g_exp
    logic signed [19:0] dz;
    assign dz   = 20'(mx_r) - 20'(tm3_r[j]);
    assign z[j] = dz[19] ? 20'd0 : dz;
    iou_exp u_exp (
      .clk (clk),
      .en  (en),
      .z_i (z[j]),
      .e_o (ex[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gt_r[1] <= gts;
      for (int k = 2; k <= 26; k++) gt_r[k] <= gt_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= 33'(ex[0]) + 33'(ex[1]) + 33'(ex[2]) + 33'(ex[3]);
      xh_r <= 33'(ex[4]) + 33'(ex[5]) + 33'(ex[6]) + 33'(ex[7]);
      i_r  <= 33'(ex[8]) + 33'(ex[9]) + 33'(ex[10]) + 33'(ex[11]);
      for (int s = 0; s < 4; s++) begin
        eps_r[s] <= 32'(ex[4 + SC0[s]]) + 32'(ex[4 + SC1[s]]);
        eis_r[s] <= 32'(ex[8 + SC0[s]]) + 32'(ex[8 + SC1[s]]);
      end
    end
  end

  assign s_sum = 34'(x_r) + 34'(xh_r);
  assign u_nxt = (s_sum > 34'(i_r)) ? s_sum - 34'(i_r) : 34'd1;

  for (genvar s = 0; s < 4; s++) begin : g_num
    logic signed [32:0] df;
    assign df = $signed({1'b0, eps_r[s]}) - $signed({1'b0, eis_r[s]});
    always_ff @(posedge clk) begin
      if (en) begin
        n1_r[s] <= (gt_r[26][s] && i_r != 33'd0) ? 33'(eis_r[s]) : 33'd0;
        d1_r[s] <= (i_r == 33'd0) ? 34'd1 : 34'(i_r);
        if (gt_r[26][s]) begin
          ng_r[s] <= df[32];
          n2_r[s] <= df[32] ? 33'(-df) : 33'(df);
        end else begin
          ng_r[s] <= 1'b0;
          n2_r[s] <= 33'(eps_r[s]);
        end
      end
    end
    iou_div u_div1 (
      .clk   (clk),
      .en    (en),
      .num_i (n1_r[s]),
      .neg_i (1'b0),
      .den_i (d1_r[s]),
      .q_o   (q1[s])
    );
    iou_div u_div2 (
      .clk   (clk),
      .en    (en),
      .num_i (n2_r[s]),
      .neg_i (ng_r[s]),
      .den_i (u_r),
      .q_o   (q2[s])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= u_nxt;
      i2_r <= i_r;
      iz_r <= (i_r == 33'd0);
    end
  end

  iou_lg2 u_lgu (
    .clk  (clk),
    .en   (en),
    .v_i  (u_r),
    .lg_o (lgu)
  );

  iou_lg2 u_lgi (
    .clk  (clk),
    .en   (en),
    .v_i  ({1'b0, i2_r}),
    .lg_o (lgi)
  );

  assign ldiff = $signed({1'b0, lgu}) - $signed({1'b0, lgi});
  assign lp    = 56'(diff_r) * 56'(LN2_Q30) + 56'h2_0000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      izd_r  <= {izd_r[20:1], iz_r};
      diff_r <= ldiff[26] ? 26'd0 : ldiff[25:0];
      lz_r   <= izd_r[21];
      loss_r <= lz_r ? LOSS_MAX : 24'(lp[55:34]);
    end
  end

  for (genvar s = 0; s < 4; s++) begin : g_grad
    logic signed [20:0] gs;
    assign gs = 21'(q2[s]) - 21'(q1[s]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (gs > 21'sd524287)       g_r[s] <= 20'sd524287;
        else if (gs < -21'sd524288) g_r[s] <= -20'sd524288;
        else                        g_r[s] <= gs[19:0];
        gd_r[1][s] <= g_r[s];
        gd_r[2][s] <= gd_r[1][s];
        gd_r[3][s] <= gd_r[2][s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vld_r[72];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tuser_r <= ok_r[72];
      if (ok_r[72]) begin
        out_tdata_r <= {gd_r[3][3], gd_r[3][2], gd_r[3][1], gd_r[3][0], loss_r};
      end else begin
        out_tdata_r <= '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire
